[rtl/sas_pkg.sv]
// Shared types, codes and microprogram for the sprite animation sequencer.
package sas_pkg;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  anim_sel;
		logic [4:0]  frame_sel;
		logic [15:0] tick_count;
		logic        loop_mode;
		logic [7:0]  duration_value;
		logic [5:0]  count_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  play_state;
		logic [3:0]  cur_anim;
		logic [4:0]  cur_frame;
		logic [7:0]  frame_time;
		logic        frame_entered;
		logic        tiles_dirty;
		logic [15:0] revision;
	} rsp_t;

	localparam logic [2:0] ACT_TICK       = 3'd0;
	localparam logic [2:0] ACT_BATCH      = 3'd1;
	localparam logic [2:0] ACT_PLAY       = 3'd2;
	localparam logic [2:0] ACT_STATIC     = 3'd3;
	localparam logic [2:0] ACT_LOAD_DUR   = 3'd4;
	localparam logic [2:0] ACT_LOAD_CNT   = 3'd5;

	localparam logic [1:0] PS_STOPPED     = 2'd0;
	localparam logic [1:0] PS_PLAYING     = 2'd1;
	localparam logic [1:0] PS_COMPLETED   = 2'd2;

	typedef logic [3:0] upc_t;

	typedef enum logic [3:0] {
		OP_DISPATCH,
		OP_READ,
		OP_TICK,
		OP_BATCH,
		OP_MOVED,
		OP_PLAY,
		OP_STATIC,
		OP_LOAD_DUR,
		OP_LOAD_CNT,
		OP_EMIT
	} uop_t;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_NOT_PLAYING,
		COND_BATCH_DONE
	} cond_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		upc_t  target;
	} ucode_t;

	localparam upc_t UA_IDLE     = 4'd0;
	localparam upc_t UA_T_READ   = 4'd1;
	localparam upc_t UA_T_STEP   = 4'd2;
	localparam upc_t UA_B_READ   = 4'd3;
	localparam upc_t UA_B_STEP   = 4'd4;
	localparam upc_t UA_B_END    = 4'd5;
	localparam upc_t UA_PLAY     = 4'd6;
	localparam upc_t UA_STATIC   = 4'd7;
	localparam upc_t UA_LOAD_DUR = 4'd8;
	localparam upc_t UA_LOAD_CNT = 4'd9;
	localparam upc_t UA_EMIT     = 4'd10;

	function automatic ucode_t ucode(input upc_t addr);
		ucode_t w;
		unique case (addr)
			UA_IDLE:     w = '{OP_DISPATCH, COND_ALWAYS,      UA_IDLE};
			UA_T_READ:   w = '{OP_READ,     COND_NOT_PLAYING, UA_EMIT};
			UA_T_STEP:   w = '{OP_TICK,     COND_ALWAYS,      UA_EMIT};
			UA_B_READ:   w = '{OP_READ,     COND_BATCH_DONE,  UA_B_END};
			UA_B_STEP:   w = '{OP_BATCH,    COND_ALWAYS,      UA_B_READ};
			UA_B_END:    w = '{OP_MOVED,    COND_ALWAYS,      UA_EMIT};
			UA_PLAY:     w = '{OP_PLAY,     COND_ALWAYS,      UA_EMIT};
			UA_STATIC:   w = '{OP_STATIC,   COND_ALWAYS,      UA_EMIT};
			UA_LOAD_DUR: w = '{OP_LOAD_DUR, COND_ALWAYS,      UA_EMIT};
			UA_LOAD_CNT: w = '{OP_LOAD_CNT, COND_ALWAYS,      UA_EMIT};
			default:     w = '{OP_EMIT,     COND_ALWAYS,      UA_IDLE};
		endcase
		return w;
	endfunction

	function automatic upc_t entry(input logic [2:0] action);
		upc_t a;
		unique case (action)
			ACT_TICK:     a = UA_T_READ;
			ACT_BATCH:    a = UA_B_READ;
			ACT_PLAY:     a = UA_PLAY;
			ACT_STATIC:   a = UA_STATIC;
			ACT_LOAD_DUR: a = UA_LOAD_DUR;
			ACT_LOAD_CNT: a = UA_LOAD_CNT;
			default:      a = UA_EMIT;
		endcase
		return a;
	endfunction

endpackage

[rtl/sas_ram.sv]
// Generic single-port-write, registered-read RAM.
module sas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/sprite_animation_sequencer_unit.sv]
// Sprite animation sequencer: microcoded control over duration and frame-count tables.
//
//  channel  dir  handshake              payload
//  cmd      in   cmd_valid / cmd_ready  sas_pkg::cmd_t
//  rsp      out  rsp_valid / rsp_ready  sas_pkg::rsp_t
//
// Microsteps from transfer through emit: unknown actions go straight to emit; play,
// static and loads act and then emit; tick reads the duration RAM, then updates unless
// not playing; batch tick repeats one duration RAM read and one update per table step.
// cmd_ready is high only at the idle microstep; a pending result does not block it.
// A result waiting on rsp_ready stalls the emit microstep only.
// Reset clears control and playback state; table contents are undefined until loaded.
module sprite_animation_sequencer_unit #(
	parameter int MAX_ANIMS  = 16,
	parameter int MAX_FRAMES = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  sas_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sas_pkg::rsp_t rsp
);
	import sas_pkg::*;

	localparam int DUR_DEPTH = MAX_ANIMS * MAX_FRAMES;
	localparam int DUR_AW    = (DUR_DEPTH > 1) ? $clog2(DUR_DEPTH) : 1;
	localparam int CNT_AW    = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;

	upc_t        upc_q;
	ucode_t      uw;
	cmd_t        cmd_q;
	logic [1:0]  mode_q;
	logic [3:0]  anim_q;
	logic [4:0]  frame_q;
	logic [7:0]  tick_q;
	logic        loop_q;
	logic [15:0] rev_q;
	logic [15:0] ticks_q;
	logic [4:0]  old_frame_q;
	logic        entered_q;
	logic        dirty_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic              dur_we;
	logic [DUR_AW-1:0] dur_waddr;
	logic [DUR_AW-1:0] dur_raddr;
	logic [7:0]        dur_rdata;
	logic              cnt_we;
	logic [CNT_AW-1:0] cnt_waddr;
	logic [CNT_AW-1:0] cnt_raddr;
	logic [5:0]        cnt_rdata;

	logic        playing;
	logic        anim_ok;
	logic        frame_ok;
	logic        cond_hit;
	logic        emit_go;
	logic [7:0]  count_eff;
	logic [7:0]  frame_inc;
	logic [4:0]  lf_frame;
	logic [7:0]  lf_tick;
	logic [1:0]  lf_mode;
	logic        lf_entered;
	logic [8:0]  leave_span;
	logic        ticks_short;
	logic [15:0] rev_inc;
	logic [15:0] rev_nxt;

	sas_ram #(.WIDTH(8), .DEPTH(DUR_DEPTH)) u_dur_ram (
		.clk   (clk),
		.we    (dur_we),
		.waddr (dur_waddr),
		.wdata (cmd_q.duration_value),
		.raddr (dur_raddr),
		.rdata (dur_rdata)
	);

	sas_ram #(.WIDTH(6), .DEPTH(MAX_ANIMS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cmd_q.count_value),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	assign uw        = ucode(upc_q);
	assign playing   = (mode_q == PS_PLAYING);
	assign anim_ok   = int'(cmd_q.anim_sel) < MAX_ANIMS;
	assign frame_ok  = int'(cmd_q.frame_sel) < MAX_FRAMES;
	assign cmd_ready = (uw.op == OP_DISPATCH);
	assign emit_go   = !rsp_valid_q || rsp_ready;

	assign dur_raddr = DUR_AW'(int'(anim_q) * MAX_FRAMES + int'(frame_q));
	assign dur_waddr = DUR_AW'(int'(cmd_q.anim_sel) * MAX_FRAMES + int'(cmd_q.frame_sel));
	assign dur_we    = (uw.op == OP_LOAD_DUR) && anim_ok && frame_ok;
	assign cnt_raddr = CNT_AW'(anim_q);
	assign cnt_waddr = CNT_AW'(cmd_q.anim_sel);
	assign cnt_we    = (uw.op == OP_LOAD_CNT) && anim_ok;

	always_comb begin
		unique case (uw.cond)
			COND_ALWAYS:      cond_hit = 1'b1;
			COND_NOT_PLAYING: cond_hit = !playing;
			COND_BATCH_DONE:  cond_hit = (ticks_q == 16'd0) || !playing;
			default:          cond_hit = 1'b1;
		endcase
	end

	// leave the current frame: advance, wrap or complete
	always_comb begin
		count_eff = (int'(cnt_rdata) > MAX_FRAMES) ? 8'(MAX_FRAMES) : {2'b00, cnt_rdata};
		frame_inc = {3'b000, frame_q} + 8'd1;
		lf_frame   = frame_q;
		lf_tick    = tick_q;
		lf_mode    = mode_q;
		lf_entered = 1'b0;
		if (frame_inc < count_eff) begin
			lf_frame   = frame_inc[4:0];
			lf_tick    = 8'd1;
			lf_entered = 1'b1;
		end else if (loop_q) begin
			lf_frame   = 5'd0;
			lf_tick    = 8'd1;
			lf_entered = 1'b1;
		end else begin
			lf_mode = PS_COMPLETED;
		end
	end

	assign leave_span  = ((tick_q >= dur_rdata) ? 9'd0 : {1'b0, dur_rdata - tick_q}) + 9'd1;
	assign ticks_short = ticks_q < {7'd0, leave_span};
	assign rev_inc     = rev_q + 16'd1;
	assign rev_nxt     = (rev_inc == 16'd0) ? 16'd1 : rev_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= UA_IDLE;
			mode_q      <= PS_STOPPED;
			anim_q      <= 4'd0;
			frame_q     <= 5'd0;
			tick_q      <= 8'd0;
			loop_q      <= 1'b0;
			rev_q       <= 16'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (uw.op == OP_EMIT && emit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (uw.op)
				OP_DISPATCH: begin
					if (cmd_valid) begin
						upc_q <= entry(cmd.action);
					end
				end
				OP_EMIT: begin
					if (emit_go) begin
						upc_q <= uw.target;
					end
				end
				default: begin
					upc_q <= cond_hit ? uw.target : upc_q + 4'd1;
				end
			endcase
			unique case (uw.op)
				OP_TICK: begin
					if (tick_q == 8'd0) begin
						tick_q <= 8'd1;
					end else if (tick_q < dur_rdata) begin
						tick_q <= tick_q + 8'd1;
					end else begin
						frame_q <= lf_frame;
						tick_q  <= lf_tick;
						mode_q  <= lf_mode;
					end
				end
				OP_BATCH: begin
					if (tick_q == 8'd0) begin
						tick_q <= 8'd1;
					end else if (ticks_short) begin
						tick_q <= tick_q + ticks_q[7:0];
					end else begin
						frame_q <= lf_frame;
						tick_q  <= lf_tick;
						mode_q  <= lf_mode;
					end
				end
				OP_PLAY: begin
					if (anim_ok) begin
						anim_q  <= cmd_q.anim_sel;
						frame_q <= 5'd0;
						tick_q  <= 8'd0;
						rev_q   <= rev_nxt;
						loop_q  <= cmd_q.loop_mode;
						mode_q  <= PS_PLAYING;
					end
				end
				OP_STATIC: begin
					if (anim_ok && frame_ok) begin
						anim_q  <= cmd_q.anim_sel;
						frame_q <= cmd_q.frame_sel;
						tick_q  <= 8'd0;
						rev_q   <= rev_nxt;
						mode_q  <= PS_STOPPED;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_DISPATCH: begin
				if (cmd_valid) begin
					cmd_q       <= cmd;
					ticks_q     <= cmd.tick_count;
					old_frame_q <= frame_q;
					entered_q   <= 1'b0;
					dirty_q     <= 1'b0;
				end
			end
			OP_TICK: begin
				if (tick_q == 8'd0) begin
					entered_q <= 1'b1;
				end else if (tick_q >= dur_rdata) begin
					entered_q <= lf_entered;
					dirty_q   <= lf_entered && (lf_frame != frame_q);
				end
			end
			OP_BATCH: begin
				if (tick_q == 8'd0) begin
					ticks_q <= ticks_q - 16'd1;
				end else if (ticks_short) begin
					ticks_q <= 16'd0;
				end else begin
					ticks_q <= ticks_q - {7'd0, leave_span};
				end
			end
			OP_MOVED: begin
				dirty_q <= (frame_q != old_frame_q);
			end
			OP_PLAY: begin
				if (anim_ok) begin
					dirty_q <= (cmd_q.anim_sel != anim_q) || (frame_q != 5'd0);
				end
			end
			OP_STATIC: begin
				if (anim_ok && frame_ok) begin
					dirty_q <= (cmd_q.anim_sel != anim_q) || (cmd_q.frame_sel != frame_q);
				end
			end
			OP_EMIT: begin
				if (emit_go) begin
					rsp_q.play_state    <= mode_q;
					rsp_q.cur_anim      <= anim_q;
					rsp_q.cur_frame     <= frame_q;
					rsp_q.frame_time    <= tick_q;
					rsp_q.frame_entered <= entered_q;
					rsp_q.tiles_dirty   <= dirty_q;
					rsp_q.revision      <= rev_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the sprite animation sequencer: directed and random playback traffic with a shadow model.
module tb_top;
	import sas_pkg::*;

	localparam int ANIMS       = 16;
	localparam int FRAMES      = 32;
	localparam int NO_MISS     = -1;
	localparam int COUNT_MISS  = ANIMS * FRAMES;
	localparam int STALL_LIMIT = 1000000;
	localparam int MAX_REPORTS = 100;
	localparam int RANDOM_ITEMS = 900;
	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	class playback_scoreboard;
		bit [1:0]  mode = PS_STOPPED;
		bit [3:0]  anim = 0;
		bit [4:0]  frame = 0;
		bit [7:0]  ftime = 0;
		bit        looping = 0;
		bit [15:0] rev = 1;
		bit [7:0]  dur [ANIMS * FRAMES];
		bit        dur_set [ANIMS * FRAMES];
		bit [5:0]  cnt [ANIMS];
		bit        cnt_set [ANIMS];
		rsp_t      rsp_due [$];
		int        errors = 0;

		function int read_dur(input bit [3:0] an, input bit [4:0] fr, inout int miss);
			bit [8:0] idx;
			idx = {an, fr};
			if (!dur_set[idx] && miss == NO_MISS)
				miss = idx;
			return dur[idx];
		endfunction

		function bit leave_frame(input bit [3:0] an, input bit lp, inout bit [4:0] fr,
				inout bit [7:0] ft, inout bit [1:0] md, inout int miss);
			int n;
			if (!cnt_set[an] && miss == NO_MISS)
				miss = COUNT_MISS + an;
			n = (cnt[an] > FRAMES) ? FRAMES : cnt[an];
			if (int'(fr) + 1 < n) begin
				fr = fr + 5'd1;
				ft = 8'd1;
				return 1'b1;
			end
			if (lp) begin
				fr = 5'd0;
				ft = 8'd1;
				return 1'b1;
			end
			md = PS_COMPLETED;
			return 1'b0;
		endfunction

		// Return the first unwritten table entry the item would read, or NO_MISS.
		function int play_step(input cmd_t c, input bit commit, output rsp_t r);
			bit [1:0]  md;
			bit [3:0]  an;
			bit [4:0]  fr;
			bit [4:0]  old;
			bit [7:0]  ft;
			bit        lp;
			bit [15:0] rv;
			bit        ent;
			bit        dirty;
			int        miss;
			int        left;
			int        d;
			int        span;
			md = mode;
			an = anim;
			fr = frame;
			ft = ftime;
			lp = looping;
			rv = rev;
			old = frame;
			ent = 1'b0;
			dirty = 1'b0;
			miss = NO_MISS;
			case (c.action)
				ACT_TICK: begin
					if (md == PS_PLAYING) begin
						if (ft == 0) begin
							ft = 8'd1;
							ent = 1'b1;
						end else begin
							d = read_dur(an, fr, miss);
							if (ft < d) begin
								ft = ft + 8'd1;
							end else begin
								ent = leave_frame(an, lp, fr, ft, md, miss);
								dirty = ent && fr != old;
							end
						end
					end
				end
				ACT_BATCH: begin
					if (c.tick_count != 0 && md == PS_PLAYING) begin
						left = c.tick_count;
						while (left > 0 && md == PS_PLAYING && miss == NO_MISS) begin
							if (ft == 0) begin
								ft = 8'd1;
								left--;
							end else begin
								d = read_dur(an, fr, miss);
								span = (ft >= d ? 0 : d - ft) + 1;
								if (left < span) begin
									ft = 8'(int'(ft) + left);
									left = 0;
								end else begin
									left -= span;
									void'(leave_frame(an, lp, fr, ft, md, miss));
								end
							end
						end
						dirty = fr != old;
					end
				end
				ACT_PLAY, ACT_STATIC: begin
					if (c.action == ACT_PLAY) begin
						dirty = c.anim_sel != an || fr != 0;
						fr = 5'd0;
						lp = c.loop_mode;
						md = PS_PLAYING;
					end else begin
						dirty = c.anim_sel != an || c.frame_sel != fr;
						fr = c.frame_sel;
						md = PS_STOPPED;
					end
					an = c.anim_sel;
					ft = 8'd0;
					rv = rv + 16'd1;
					if (rv == 0)
						rv = 16'd1;
				end
				ACT_LOAD_DUR: begin
					if (commit) begin
						dur[{c.anim_sel, c.frame_sel}] = c.duration_value;
						dur_set[{c.anim_sel, c.frame_sel}] = 1'b1;
					end
				end
				ACT_LOAD_CNT: begin
					if (commit) begin
						cnt[c.anim_sel] = c.count_value;
						cnt_set[c.anim_sel] = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (commit) begin
				mode = md;
				anim = an;
				frame = fr;
				ftime = ft;
				looping = lp;
				rev = rv;
			end
			r.play_state = md;
			r.cur_anim = an;
			r.cur_frame = fr;
			r.frame_time = ft;
			r.frame_entered = ent;
			r.tiles_dirty = dirty;
			r.revision = rv;
			return miss;
		endfunction

		function void note_cmd(input cmd_t c);
			rsp_t r;
			void'(play_step(c, 1'b1, r));
			rsp_due.push_back(r);
		endfunction

		function void cmp(input string field, input logic [15:0] want, input logic [15:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("%s: expected %0d, got %0d", field, want, got);
			end
		endfunction

		function void check_rsp(input rsp_t got);
			rsp_t want;
			if (rsp_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("result transfer with nothing pending");
				return;
			end
			want = rsp_due.pop_front();
			cmp("play_state", want.play_state, got.play_state);
			cmp("cur_anim", want.cur_anim, got.cur_anim);
			cmp("cur_frame", want.cur_frame, got.cur_frame);
			cmp("frame_time", want.frame_time, got.frame_time);
			cmp("frame_entered", want.frame_entered, got.frame_entered);
			cmp("tiles_dirty", want.tiles_dirty, got.tiles_dirty);
			cmp("revision", want.revision, got.revision);
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cmd_valid;
	logic  cmd_ready;
	cmd_t  cmd;
	logic  rsp_valid;
	logic  rsp_ready;
	rsp_t  rsp;

	bit    calm;
	int    stall_cycles = 0;
	playback_scoreboard sb;
	playback_scoreboard stim_plan;

	sprite_animation_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			sb.check_rsp(rsp);
		if (cmd_valid && cmd_ready)
			sb.note_cmd(cmd);
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	function automatic int idle_len();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.action = 3'($urandom_range(0, 7));
		c.anim_sel = 4'($urandom_range(0, 15));
		c.frame_sel = 5'($urandom_range(0, 31));
		c.tick_count = 16'($urandom_range(0, 65535));
		c.loop_mode = 1'($urandom_range(0, 1));
		c.duration_value = 8'($urandom_range(0, 255));
		c.count_value = 6'($urandom_range(0, 63));
		return c;
	endfunction

	function automatic cmd_t mk(input logic [2:0] act, input int a, input int f, input int ticks,
			input int lm, input int dv, input int cv);
		cmd_t c;
		c.action = act;
		c.anim_sel = 4'(a);
		c.frame_sel = 5'(f);
		c.tick_count = 16'(ticks);
		c.loop_mode = 1'(lm);
		c.duration_value = 8'(dv);
		c.count_value = 6'(cv);
		return c;
	endfunction

	function automatic logic [3:0] pick_anim();
		if ($urandom_range(0, 1) == 0)
			return 4'($urandom_range(0, 3));
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [5:0] pick_count();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return 6'($urandom_range(1, 6));
		if (p < 85)
			return 6'($urandom_range(7, 32));
		if (p < 95)
			return 6'($urandom_range(33, 63));
		return 6'd0;
	endfunction

	function automatic logic [7:0] pick_duration();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 8'($urandom_range(1, 6));
		if (p < 70)
			return 8'd0;
		if (p < 90)
			return 8'($urandom_range(7, 40));
		return 8'($urandom_range(41, 255));
	endfunction

	function automatic logic [15:0] pick_ticks();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return 16'($urandom_range(1, 20));
		if (p < 95)
			return 16'($urandom_range(21, 600));
		if (p < 99)
			return 16'($urandom_range(601, 65535));
		return 16'd0;
	endfunction

	// Load the table entry an item would read before it was written.
	function automatic cmd_t fill_cmd(input int miss);
		cmd_t c;
		c = rand_cmd();
		if (miss >= COUNT_MISS) begin
			c.action = ACT_LOAD_CNT;
			c.anim_sel = 4'(miss - COUNT_MISS);
			c.count_value = pick_count();
		end else begin
			c.action = ACT_LOAD_DUR;
			c.anim_sel = 4'(miss / FRAMES);
			c.frame_sel = 5'(miss % FRAMES);
			c.duration_value = pick_duration();
		end
		return c;
	endfunction

	task automatic send(input cmd_t c);
		rsp_t r;
		int   miss;
		int   gap;
		miss = stim_plan.play_step(c, 1'b0, r);
		if (miss != NO_MISS)
			c = fill_cmd(miss);
		void'(stim_plan.play_step(c, 1'b1, r));
		gap = idle_len();
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	initial begin
		int n;
		rsp_ready = 1'b0;
		@(posedge clk);
		forever begin
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
			n = idle_len();
			if (n != 0) begin
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		cmd_t c;
		int   done_items;
		bit   ignored;
		int   p;
		sb = new;
		stim_plan = new;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send(mk(ACT_BATCH, 0, 0, 16'hFFFF, 0, 0, 0));
		send(mk(ACT_SPARE_HI, 15, 31, 16'hFFFF, 1, 255, 63));
		send(mk(ACT_LOAD_CNT, 15, 0, 0, 0, 0, 2));
		send(mk(ACT_LOAD_CNT, 0, 0, 0, 0, 0, 0));
		send(mk(ACT_LOAD_DUR, 15, 0, 0, 0, 0, 0));
		send(mk(ACT_LOAD_DUR, 15, 1, 0, 0, 3, 0));
		send(mk(ACT_LOAD_DUR, 0, 0, 0, 0, 1, 0));
		send(mk(ACT_PLAY, 15, 0, 0, 1, 0, 0));
		repeat (8) send(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send(mk(ACT_LOAD_DUR, 15, 1, 0, 0, 1, 0));
		send(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send(mk(ACT_BATCH, 0, 0, 16'hFFFF, 0, 0, 0));
		send(mk(ACT_PLAY, 15, 0, 0, 0, 0, 0));
		send(mk(ACT_BATCH, 0, 0, 300, 0, 0, 0));
		send(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send(mk(ACT_PLAY, 0, 0, 0, 1, 0, 0));
		send(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send(mk(ACT_TICK, 0, 0, 0, 0, 0, 0));
		send(mk(ACT_STATIC, 15, 31, 0, 0, 0, 0));
		send(mk(ACT_STATIC, 15, 31, 0, 0, 0, 0));
		send(mk(ACT_LOAD_CNT, 1, 0, 0, 0, 0, 63));

		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 59) == 0)
				calm = !calm;
			c = rand_cmd();
			p = $urandom_range(0, 99);
			if (stim_plan.mode != PS_PLAYING && $urandom_range(0, 9) < 6)
				c.action = ACT_PLAY;
			else if (p < 45)
				c.action = ACT_TICK;
			else if (p < 60)
				c.action = ACT_BATCH;
			else if (p < 68)
				c.action = ACT_PLAY;
			else if (p < 73)
				c.action = ACT_STATIC;
			else if (p < 85)
				c.action = ACT_LOAD_DUR;
			else if (p < 93)
				c.action = ACT_LOAD_CNT;
			else
				c.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
			case (c.action)
				ACT_BATCH: begin
					if (stim_plan.mode == PS_PLAYING)
						c.tick_count = pick_ticks();
				end
				ACT_PLAY: c.anim_sel = pick_anim();
				ACT_LOAD_DUR: begin
					c.anim_sel = pick_anim();
					if ($urandom_range(0, 9) < 7)
						c.frame_sel = 5'($urandom_range(0, 7));
					c.duration_value = pick_duration();
				end
				ACT_LOAD_CNT: begin
					c.anim_sel = pick_anim();
					c.count_value = pick_count();
				end
				default: begin
				end
			endcase
			ignored = c.action == ACT_SPARE_LO || c.action == ACT_SPARE_HI
				|| ((c.action == ACT_TICK || c.action == ACT_BATCH)
					&& stim_plan.mode != PS_PLAYING)
				|| (c.action == ACT_BATCH && c.tick_count == 0);
			if (!ignored)
				done_items++;
			send(c);
		end
		cmd_valid <= 1'b0;

		while (sb.rsp_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
